/* sv/button_click_hold_qualifier_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the button click and hold qualifier
// Immediate reporting wrappers around concurrent properties on the block clock.
// ----------------------------------------------------------------------------
`ifndef BUTTON_CLICK_HOLD_QUALIFIER_MACROS_SVH
`define BUTTON_CLICK_HOLD_QUALIFIER_MACROS_SVH

// Property checked only outside reset.
`define BCHQ_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Property checked at every edge, reset included.
`define BCHQ_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

/* sv/bchq_pkg.sv */
// ----------------------------------------------------------------------------
// bchq_pkg
// Types, register indexes and command codes of the button click and hold qualifier.
// ----------------------------------------------------------------------------
`default_nettype none

package bchq_pkg;

   // Widths of the fields and registers.
   localparam int TimeWidth  = 32;
   localparam int MsWidth    = 16;
   localparam int CountWidth = 16;
   localparam int IndexWidth = 2;
   localparam int DataWidth  = 16;

   // Register reset values.
   localparam logic [MsWidth-1:0] DebounceReset = 16'd30;
   localparam logic [MsWidth-1:0] HoldReset     = 16'd150;

   // Register indexes of the configuration port.
   localparam logic [IndexWidth-1:0] RegActiveHigh   = 2'd0;
   localparam logic [IndexWidth-1:0] RegMode         = 2'd1;
   localparam logic [IndexWidth-1:0] RegDebounceMs   = 2'd2;
   localparam logic [IndexWidth-1:0] RegHoldInterval = 2'd3;

   // Button behavior codes.
   localparam logic [1:0] ModeNone   = 2'd0;
   localparam logic [1:0] ModeToggle = 2'd1;
   localparam logic [1:0] ModeDimmer = 2'd2;

   // Lamp command codes.
   typedef enum logic [1:0] {
      CMD_NONE   = 2'd0,
      CMD_TOGGLE = 2'd1,
      CMD_UP     = 2'd2,
      CMD_DOWN   = 2'd3
   } command_type;

   // One button poll.
   typedef struct packed {
      logic                 raw_level;
      logic [TimeWidth-1:0] now_ms;
      logic                 at_full_brightness;
   } req_type;

   // One qualified result.
   typedef struct packed {
      command_type           command;
      logic                  pressed;
      logic [CountWidth-1:0] hold_count;
   } rsp_type;

endpackage

`default_nettype wire

/* sv/button_click_hold_qualifier.sv */
// ----------------------------------------------------------------------------
// button_click_hold_qualifier
// Debounces polled button levels and turns clicks and holds into lamp commands.
// ----------------------------------------------------------------------------
// Each poll gives exactly one result. A poll is captured in an input register,
// then compare and subtract logic updates the button state and loads the result
// register, so the block takes one poll per cycle unless a waiting result is
// not taken; the result is valid once the poll has gone through the input
// register and then the result register. The input register and the result
// register move together: while a result waits, one more poll is held in the
// input register. Configuration writes are always accepted and take effect on
// the next edge; they are meant to be made while no poll is in flight.
`default_nettype none

`include "button_click_hold_qualifier_macros.svh"

module button_click_hold_qualifier (
   input  wire                                  clock,
   input  wire                                  reset,
   input  wire                                  req_valid,
   output logic                                 req_ready,
   input  bchq_pkg::req_type                    req_data,
   output logic                                 rsp_valid,
   input  wire                                  rsp_ready,
   output bchq_pkg::rsp_type                    rsp_data,
   input  wire                                  csr_valid,
   output logic                                 csr_ready,
   input  wire  [bchq_pkg::IndexWidth-1:0]      csr_index,
   input  wire  [bchq_pkg::DataWidth-1:0]       csr_wdata
);

   // Configuration registers.
   logic                            active_high_ff;
   logic [1:0]                      mode_ff;
   logic [bchq_pkg::MsWidth-1:0]    debounce_ff;
   logic [bchq_pkg::MsWidth-1:0]    interval_ff;

   // Button state.
   logic                            prev_active_ff, prev_active_in;
   logic                            stable_ff, stable_in;
   logic [bchq_pkg::TimeWidth-1:0]  change_time_ff, change_time_in;
   logic [bchq_pkg::TimeWidth-1:0]  hold_time_ff, hold_time_in;
   logic [bchq_pkg::CountWidth-1:0] holds_ff, holds_in;
   logic                            dim_up_ff, dim_up_in;

   // Pipeline registers.
   logic                            s1_valid_ff;
   bchq_pkg::req_type               s1_data_ff;
   logic                            rsp_valid_ff;
   bchq_pkg::rsp_type               rsp_data_ff, rsp_data_in;

   logic                            advance;
   logic                            active;
   logic [bchq_pkg::TimeWidth-1:0]  since_change;
   logic [bchq_pkg::TimeWidth-1:0]  since_hold;
   logic                            holds_full;
   logic [bchq_pkg::CountWidth-1:0] holds_press;
   logic [bchq_pkg::TimeWidth-1:0]  hold_base;
   bchq_pkg::command_type           cmd;

   // Handshake: the input register moves whenever the result register is empty or being read.
   assign advance   = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !s1_valid_ff || advance;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
   assign csr_ready = 1'b1;

   // Configuration writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         active_high_ff <= 1'b0;
         mode_ff        <= bchq_pkg::ModeNone;
         debounce_ff    <= bchq_pkg::DebounceReset;
         interval_ff    <= bchq_pkg::HoldReset;
      end else if (csr_valid) begin
         unique case (csr_index)
            bchq_pkg::RegActiveHigh:   active_high_ff <= csr_wdata[0];
            bchq_pkg::RegMode:         mode_ff        <= csr_wdata[1:0];
            bchq_pkg::RegDebounceMs:   debounce_ff    <= csr_wdata;
            bchq_pkg::RegHoldInterval: interval_ff    <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Debounce, press and release qualification, then hold timing.
   always_comb begin
      active         = (s1_data_ff.raw_level == active_high_ff);
      prev_active_in = active;
      change_time_in = (active != prev_active_ff) ? s1_data_ff.now_ms : change_time_ff;
      since_change   = s1_data_ff.now_ms - change_time_in;
      stable_in      = stable_ff;
      hold_base      = hold_time_ff;
      holds_press    = holds_ff;
      dim_up_in      = dim_up_ff;
      cmd            = bchq_pkg::CMD_NONE;

      // A level change is confirmed once it has outlasted the debounce time.
      if (since_change > {{(bchq_pkg::TimeWidth-bchq_pkg::MsWidth){1'b0}}, debounce_ff}
          && active != stable_ff) begin
         stable_in = active;
         if (active) begin
            hold_base   = s1_data_ff.now_ms;
            dim_up_in   = !s1_data_ff.at_full_brightness;
            holds_press = '0;
         end else if (holds_ff == '0) begin
            if (mode_ff == bchq_pkg::ModeToggle || mode_ff == bchq_pkg::ModeDimmer) begin
               cmd = bchq_pkg::CMD_TOGGLE;
            end
         end
      end

      // Hold events repeat every interval while the button stays down.
      since_hold   = s1_data_ff.now_ms - hold_base;
      holds_full   = (holds_press == {bchq_pkg::CountWidth{1'b1}});
      holds_in     = holds_press;
      hold_time_in = hold_base;
      if (stable_in
          && since_hold >= {{(bchq_pkg::TimeWidth-bchq_pkg::MsWidth){1'b0}}, interval_ff}) begin
         if (!holds_full) begin
            holds_in = holds_press + 1'b1;
         end
         if (mode_ff == bchq_pkg::ModeToggle) begin
            if (holds_in == {{(bchq_pkg::CountWidth-1){1'b0}}, 1'b1}) begin
               cmd = bchq_pkg::CMD_TOGGLE;
            end
         end else if (mode_ff == bchq_pkg::ModeDimmer) begin
            cmd = dim_up_in ? bchq_pkg::CMD_UP : bchq_pkg::CMD_DOWN;
         end
         hold_time_in = s1_data_ff.now_ms;
      end

      rsp_data_in.command    = cmd;
      rsp_data_in.pressed    = stable_in;
      rsp_data_in.hold_count = holds_in;
   end

   // Button state advances with each poll that leaves the input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         prev_active_ff <= 1'b0;
         stable_ff      <= 1'b0;
         change_time_ff <= '0;
         hold_time_ff   <= '0;
         holds_ff       <= '0;
         dim_up_ff      <= 1'b1;
      end else if (advance) begin
         prev_active_ff <= prev_active_in;
         stable_ff      <= stable_in;
         change_time_ff <= change_time_in;
         hold_time_ff   <= hold_time_in;
         holds_ff       <= holds_in;
         dim_up_ff      <= dim_up_in;
      end
   end

   // Input register and result register control.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_ready) begin
            s1_valid_ff <= req_valid;
         end
         if (advance) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         s1_data_ff <= req_data;
      end
      if (advance) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   // Checks on the qualification logic and the pipeline control.
   `BCHQ_ASSERT_ALWAYS(a_reset_empty, reset |=> !s1_valid_ff && !rsp_valid_ff, "pipeline not empty after reset")
   `BCHQ_ASSERT(a_held_poll_kept, s1_valid_ff && !advance |=> s1_valid_ff && $stable(s1_data_ff), "waiting poll lost")
   `BCHQ_ASSERT(a_click_no_holds, rsp_valid_ff && rsp_data_ff.command == bchq_pkg::CMD_TOGGLE && !rsp_data_ff.pressed |-> rsp_data_ff.hold_count == '0, "click after holds")
   `BCHQ_ASSERT(a_dim_when_pressed, rsp_valid_ff && (rsp_data_ff.command == bchq_pkg::CMD_UP || rsp_data_ff.command == bchq_pkg::CMD_DOWN) |-> rsp_data_ff.pressed && rsp_data_ff.hold_count != '0, "dimming without a hold")

endmodule

`default_nettype wire
